### hw/rtl/pdct_pkg.sv
// pdct_pkg: shared types and constants for the pair dedup consistency table
// used by pdct_front, pdct_back and the top level; no dependencies
`default_nettype none

package pdct_pkg;

	localparam int PAIRS_PER_ITEM = 4;
	localparam int STAR_W         = 32;
	localparam int FIELD_W        = 16;
	localparam int MASK_W         = PAIRS_PER_ITEM;
	localparam int COUNT_OUT_W    = 7;
	localparam int QUEUE_DEPTH    = 2;

	// one match as it travels from the front queue to the back engine
	typedef struct packed {
		logic                                     start_set;
		logic [PAIRS_PER_ITEM-1:0][STAR_W-1:0]    star;
		logic [PAIRS_PER_ITEM-1:0][FIELD_W-1:0]   field;
	} item_t;

	// handoff status from the front queue
	typedef struct packed {
		logic  valid;
		item_t item;
	} queue_out_t;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_DECIDE = 4'b0100,
		ST_FINISH = 4'b1000
	} back_state_t;

endpackage

`default_nettype wire

### hw/rtl/pdct_front.sv
// pdct_front: accepts match transactions and holds them in a short queue
// depends on pdct_pkg
`default_nettype none

module pdct_front
	import pdct_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire item_t      push_item,
	output logic            full,
	output queue_out_t      q_out,
	input  wire logic       pop
);

	localparam int PW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);

	item_t          slot_q [QUEUE_DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [QCW-1:0] fill_q;
	logic           do_push;
	logic           do_pop;

	assign full    = (fill_q == QCW'(QUEUE_DEPTH));
	assign do_push = push && !full;
	assign do_pop  = pop && (fill_q != '0);

	assign q_out.valid = (fill_q != '0);
	assign q_out.item  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= QCW'(QUEUE_DEPTH))
		else $error("queue fill above depth");

endmodule

`default_nettype wire

### hw/rtl/pdct_back.sv
// pdct_back: pair table engine, scans the stored pairs one entry a cycle
// depends on pdct_pkg; holds the star and field table memories
`default_nettype none

module pdct_back
	import pdct_pkg::*;
#(
	parameter int MAX_PAIRS = 64
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire queue_out_t        q_out,
	output logic                   pop,
	output logic                   done,
	output logic [MASK_W-1:0]      new_mask,
	output logic [COUNT_OUT_W-1:0] pair_count,
	output logic                   consistent,
	output logic                   overflow
);

	localparam int AW = $clog2(MAX_PAIRS);
	localparam int CW = $clog2(MAX_PAIRS + 1);
	localparam int KW = $clog2(PAIRS_PER_ITEM);

	logic [STAR_W-1:0]  star_mem  [MAX_PAIRS];
	logic [FIELD_W-1:0] field_mem [MAX_PAIRS];

	back_state_t        state_q;
	item_t              item_q;
	logic [KW-1:0]      k_q;
	logic [CW-1:0]      cnt_q;
	logic [CW-1:0]      issue_q;
	logic               cmp_v_s1;
	logic [STAR_W-1:0]  star_rd_s1;
	logic [FIELD_W-1:0] field_rd_s1;
	logic               clash_q;
	logic               dup_q;
	logic               cons_q;
	logic               ovf_q;
	logic [MASK_W-1:0]  mask_q;
	logic               done_q;
	logic [MASK_W-1:0]  res_mask_q;
	logic [CW-1:0]      res_cnt_q;
	logic               res_cons_q;
	logic               res_ovf_q;

	logic [STAR_W-1:0]  cur_star;
	logic [FIELD_W-1:0] cur_field;
	logic               hit_star;
	logic               hit_field;
	logic               rd_en;
	logic               wr_en;
	logic               table_full;
	logic [CW+COUNT_OUT_W-1:0] cnt_ext;

	assign cur_star   = item_q.star[k_q];
	assign cur_field  = item_q.field[k_q];
	assign hit_star   = (star_rd_s1 == cur_star);
	assign hit_field  = (field_rd_s1 == cur_field);
	assign table_full = (cnt_q == CW'(MAX_PAIRS));
	assign rd_en      = (state_q == ST_SCAN) && (issue_q < cnt_q) &&
	                    !(cmp_v_s1 && hit_star && hit_field);
	assign wr_en      = (state_q == ST_DECIDE) && !dup_q && !table_full;
	assign pop        = (state_q == ST_IDLE) && q_out.valid;

	// table memories, one write and one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			star_mem[cnt_q[AW-1:0]]  <= cur_star;
			field_mem[cnt_q[AW-1:0]] <= cur_field;
		end
		if (rd_en) begin
			star_rd_s1  <= star_mem[issue_q[AW-1:0]];
			field_rd_s1 <= field_mem[issue_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_q <= q_out.item;
		end
		if (state_q == ST_FINISH) begin
			res_mask_q <= mask_q;
			res_cnt_q  <= cnt_q;
			res_cons_q <= cons_q;
			res_ovf_q  <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			k_q      <= '0;
			cnt_q    <= '0;
			issue_q  <= '0;
			cmp_v_s1 <= 1'b0;
			clash_q  <= 1'b0;
			dup_q    <= 1'b0;
			cons_q   <= 1'b1;
			ovf_q    <= 1'b0;
			mask_q   <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (q_out.valid) begin
						if (q_out.item.start_set) begin
							cnt_q  <= '0;
							cons_q <= 1'b1;
							ovf_q  <= 1'b0;
						end
						k_q      <= '0;
						mask_q   <= '0;
						issue_q  <= '0;
						cmp_v_s1 <= 1'b0;
						clash_q  <= 1'b0;
						dup_q    <= 1'b0;
						state_q  <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (cmp_v_s1 && hit_star && hit_field) begin
						// exact duplicate ends the scan at once
						dup_q    <= 1'b1;
						cmp_v_s1 <= 1'b0;
						state_q  <= ST_DECIDE;
					end else begin
						if (cmp_v_s1 && (hit_star || hit_field)) begin
							clash_q <= 1'b1;
						end
						cmp_v_s1 <= rd_en;
						if (rd_en) begin
							issue_q <= issue_q + 1'b1;
						end else if (!cmp_v_s1) begin
							state_q <= ST_DECIDE;
						end
					end
				end
				ST_DECIDE: begin
					if (!dup_q) begin
						if (table_full) begin
							ovf_q <= 1'b1;
						end else begin
							cnt_q     <= cnt_q + 1'b1;
							mask_q[k_q] <= 1'b1;
							if (clash_q) begin
								cons_q <= 1'b0;
							end
						end
					end
					issue_q  <= '0;
					cmp_v_s1 <= 1'b0;
					clash_q  <= 1'b0;
					dup_q    <= 1'b0;
					if (k_q == KW'(PAIRS_PER_ITEM - 1)) begin
						state_q <= ST_FINISH;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= ST_SCAN;
					end
				end
				ST_FINISH: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// count is reported masked to the output width
	assign cnt_ext    = {{COUNT_OUT_W{1'b0}}, res_cnt_q};
	assign done       = done_q;
	assign new_mask   = res_mask_q;
	assign pair_count = cnt_ext[COUNT_OUT_W-1:0];
	assign consistent = res_cons_q;
	assign overflow   = res_ovf_q;

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe longer than one cycle");

	a_issue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		issue_q <= cnt_q)
		else $error("scan index beyond stored count");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_PAIRS))
		else $error("stored count beyond table depth");

	a_write_grows: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> (cnt_q == $past(cnt_q) + 1'b1))
		else $error("table write without count step");

endmodule

`default_nettype wire

### hw/rtl/pair_dedup_consistency_table.sv
// pair_dedup_consistency_table: top level of the distinct pair table
// depends on pdct_pkg, pdct_front and pdct_back
`default_nettype none

// A match transaction (four star/field pairs and a start_set flag) is taken
// at a rising edge with start high and busy low. The front holds up to two
// matches in a queue, so busy rises only when that queue is full. The back
// engine works through the four pairs in order; for each pair it reads the
// stored table one entry per cycle from a memory with one write and one
// registered read port, and then decides whether to append the pair. It
// picks each match up from the queue while idle, and a finish step after
// the last pair registers the result. The scan of a pair stops early on an
// exact duplicate. Each match gives one result, shown for a single cycle
// with done high; the receiver cannot stall it, so it must take the result
// in that cycle. The table needs no clearing after reset: only entries
// below the stored count are ever read.

module pair_dedup_consistency_table
	import pdct_pkg::*;
#(
	parameter int MAX_PAIRS = 64
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	output logic                        busy,
	input  wire logic                   start_set,
	input  wire logic [STAR_W-1:0]      star_a,
	input  wire logic [FIELD_W-1:0]     field_a,
	input  wire logic [STAR_W-1:0]      star_b,
	input  wire logic [FIELD_W-1:0]     field_b,
	input  wire logic [STAR_W-1:0]      star_c,
	input  wire logic [FIELD_W-1:0]     field_c,
	input  wire logic [STAR_W-1:0]      star_d,
	input  wire logic [FIELD_W-1:0]     field_d,
	output logic                        done,
	output logic [MASK_W-1:0]           new_mask,
	output logic [COUNT_OUT_W-1:0]      pair_count,
	output logic                        consistent,
	output logic                        overflow
);

	item_t      push_item;
	queue_out_t q_out;
	logic       full;
	logic       pop;

	// pack the pairs, pair a in slot 0
	assign push_item.start_set = start_set;
	assign push_item.star[0]   = star_a;
	assign push_item.star[1]   = star_b;
	assign push_item.star[2]   = star_c;
	assign push_item.star[3]   = star_d;
	assign push_item.field[0]  = field_a;
	assign push_item.field[1]  = field_b;
	assign push_item.field[2]  = field_c;
	assign push_item.field[3]  = field_d;

	// busy only while the front queue has no free slot
	assign busy = full;

	pdct_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (start),
		.push_item (push_item),
		.full      (full),
		.q_out     (q_out),
		.pop       (pop)
	);

	// scan engine and table memories
	pdct_back #(
		.MAX_PAIRS (MAX_PAIRS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_out      (q_out),
		.pop        (pop),
		.done       (done),
		.new_mask   (new_mask),
		.pair_count (pair_count),
		.consistent (consistent),
		.overflow   (overflow)
	);

endmodule

`default_nettype wire

### verif/tb.sv
// tb: self-checking testbench for pair_dedup_consistency_table
// depends on pdct_pkg and the pair_dedup_consistency_table rtl

module tb;
	import pdct_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// table depth used for the dut and for the predictor
	localparam int TABLE_DEPTH = 64;
	// slowest match: every pair scans a full table
	localparam int MATCH_CYCLES = 4 * TABLE_DEPTH + 14;
	// cycles left after the last result to catch stray results
	localparam int SETTLE_CYCLES = MATCH_CYCLES + 20;
	// slowest run several times over
	localparam int CYCLE_LIMIT = 2_500_000;
	localparam int RANDOM_ITEMS = 1900;

	// one expected result transaction
	typedef struct packed {
		logic [MASK_W-1:0]      mask;
		logic [COUNT_OUT_W-1:0] count;
		logic                   consistent;
		logic                   overflow;
	} table_result_t;

	// how the pairs of a random session are drawn
	typedef enum int {
		MODE_CONSISTENT,
		MODE_SMALL,
		MODE_WIDE,
		MODE_FILL,
		MODE_MIXED
	} session_mode_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               start_set = 1'b0;
	logic [STAR_W-1:0]  star_a = '0;
	logic [FIELD_W-1:0] field_a = '0;
	logic [STAR_W-1:0]  star_b = '0;
	logic [FIELD_W-1:0] field_b = '0;
	logic [STAR_W-1:0]  star_c = '0;
	logic [FIELD_W-1:0] field_c = '0;
	logic [STAR_W-1:0]  star_d = '0;
	logic [FIELD_W-1:0] field_d = '0;
	logic               busy;
	logic               done;
	logic [MASK_W-1:0]  new_mask;
	logic [COUNT_OUT_W-1:0] pair_count;
	logic               consistent;
	logic               overflow;

	pair_dedup_consistency_table #(
		.MAX_PAIRS(TABLE_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.start_set(start_set),
		.star_a(star_a),
		.field_a(field_a),
		.star_b(star_b),
		.field_b(field_b),
		.star_c(star_c),
		.field_c(field_c),
		.star_d(star_d),
		.field_d(field_d),
		.done(done),
		.new_mask(new_mask),
		.pair_count(pair_count),
		.consistent(consistent),
		.overflow(overflow)
	);

	always #5 clk = ~clk;

	// predictor copy of the pair table and its flags
	logic [STAR_W-1:0]  kept_star [TABLE_DEPTH];
	logic [FIELD_W-1:0] kept_field [TABLE_DEPTH];
	int                 kept_count = 0;
	bit                 table_consistent = 1'b1;
	bit                 table_overflow = 1'b0;

	// results still owed by the dut, oldest first
	table_result_t pending_results[$];

	int  fail_count = 0;
	int  cycle_count = 0;
	bit  idle_off = 1'b0;   // back-to-back sending for the current phase
	int  sent_items = 0;

	// one pair against the table: 1 when it gets appended
	function automatic bit insert_pair(logic [STAR_W-1:0] s, logic [FIELD_W-1:0] f);
		bit clash;
		clash = 1'b0;
		for (int i = 0; i < kept_count; i++) begin
			// exact duplicate is skipped, even next to an earlier clash
			if (kept_star[i] == s && kept_field[i] == f)
				return 1'b0;
			if (kept_star[i] == s || kept_field[i] == f)
				clash = 1'b1;
		end
		// full table drops the pair, and the clash does not count
		if (kept_count >= TABLE_DEPTH) begin
			table_overflow = 1'b1;
			return 1'b0;
		end
		kept_star[kept_count] = s;
		kept_field[kept_count] = f;
		kept_count++;
		if (clash)
			table_consistent = 1'b0;
		return 1'b1;
	endfunction

	// expected result of one accepted match
	function automatic table_result_t predict_match(item_t m);
		table_result_t r;
		// clear happens before the pairs of the same match
		if (m.start_set) begin
			kept_count = 0;
			table_consistent = 1'b1;
			table_overflow = 1'b0;
		end
		r.mask = '0;
		for (int k = 0; k < PAIRS_PER_ITEM; k++)
			r.mask[k] = insert_pair(m.star[k], m.field[k]);
		r.count = kept_count[COUNT_OUT_W-1:0];
		r.consistent = table_consistent;
		r.overflow = table_overflow;
		return r;
	endfunction

	function automatic item_t pack_match(bit set,
			int s0, int f0, int s1, int f1,
			int s2, int f2, int s3, int f3);
		item_t m;
		m.start_set = set;
		m.star[0] = STAR_W'(s0);
		m.field[0] = FIELD_W'(f0);
		m.star[1] = STAR_W'(s1);
		m.field[1] = FIELD_W'(f1);
		m.star[2] = STAR_W'(s2);
		m.field[2] = FIELD_W'(f2);
		m.star[3] = STAR_W'(s3);
		m.field[3] = FIELD_W'(f3);
		return m;
	endfunction

	// drive one match at a falling edge and hold it until the dut takes it;
	// start stays high on exit so back-to-back matches never drop it
	task automatic send_match(item_t m);
		int gap;
		gap = idle_off ? 0 : $urandom_range(0, 11);
		@(negedge clk);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		start_set <= m.start_set;
		star_a <= m.star[0];
		field_a <= m.field[0];
		star_b <= m.star[1];
		field_b <= m.field[1];
		star_c <= m.star[2];
		field_c <= m.field[2];
		star_d <= m.star[3];
		field_d <= m.field[3];
		// transaction completes at the first rising edge with busy low
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_results.push_back(predict_match(m));
	endtask

	// result checker: done marks a single-cycle result transaction
	always @(posedge clk) begin
		table_result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("result with no match outstanding: mask %h count %0d",
					new_mask, pair_count);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (new_mask !== want.mask) begin
					$error("new_mask: expected %h, got %h", want.mask, new_mask);
					fail_count++;
				end
				if (pair_count !== want.count) begin
					$error("pair_count: expected %0d, got %0d", want.count, pair_count);
					fail_count++;
				end
				if (consistent !== want.consistent) begin
					$error("consistent: expected %b, got %b", want.consistent, consistent);
					fail_count++;
				end
				if (overflow !== want.overflow) begin
					$error("overflow: expected %b, got %b", want.overflow, overflow);
					fail_count++;
				end
			end
		end
	end

	// watchdog on the whole run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("pair_dedup_consistency_table test failed");
			$finish;
		end
	end

	// all-zero and all-one ids; first match right after reset has no clear,
	// and its last two pairs clash on the star and the field id
	task automatic test_extremes();
		send_match(pack_match(1'b0,
			32'h0000_0000, 'h0000, 32'hFFFF_FFFF, 'hFFFF,
			32'hFFFF_FFFF, 'h0000, 32'h0000_0000, 'hFFFF));
		send_match(pack_match(1'b1,
			32'hAAAA_AAAA, 'hAAAA, 32'h5555_5555, 'h5555,
			32'h0000_0000, 'h0000, 32'hFFFF_FFFF, 'hFFFF));
	endtask

	// later pairs see pairs appended earlier in the same match
	task automatic test_duplicates_in_match();
		send_match(pack_match(1'b1, 5, 7, 5, 7, 9, 3, 9, 3));
	endtask

	// exact duplicates are skipped even when another entry clashes with them
	task automatic test_duplicate_after_conflict();
		send_match(pack_match(1'b1, 1, 1, 1, 2, 3, 3, 4, 4));
		send_match(pack_match(1'b0, 1, 2, 1, 1, 3, 3, 4, 4));
	endtask

	// fill to the last entry, then drop new pairs while duplicates still match
	task automatic test_full_table();
		for (int g = 0; g < TABLE_DEPTH / PAIRS_PER_ITEM; g++)
			send_match(pack_match(g == 0,
				1000 + 4 * g, 2000 + 4 * g, 1001 + 4 * g, 2001 + 4 * g,
				1002 + 4 * g, 2002 + 4 * g, 1003 + 4 * g, 2003 + 4 * g));
		// dropped pair with a clashing star must leave consistency alone
		send_match(pack_match(1'b0, 1000, 2000, 5000, 6000, 1000, 7000, 1001, 2001));
		send_match(pack_match(1'b0, 1002, 2002, 1003, 2003, 1004, 2004, 1005, 2005));
	endtask

	// clear on a full, overflowed table; the pairs of the same match then
	// see an empty table
	task automatic test_start_clear();
		send_match(pack_match(1'b1, 1000, 2000, 1000, 2000, 1000, 2001, 42, 2000));
	endtask

	// one random pair for the given session style
	function automatic void pick_pair(session_mode_t mode, logic [STAR_W-1:0] base_s,
			logic [FIELD_W-1:0] base_f, int pool, inout int fill_idx,
			output logic [STAR_W-1:0] s, output logic [FIELD_W-1:0] f);
		int i;
		case (mode)
			MODE_SMALL: begin
				s = $urandom_range(0, 5);
				f = FIELD_W'($urandom_range(0, 5));
			end
			MODE_WIDE: begin
				s = $urandom;
				f = FIELD_W'($urandom_range(0, 16'hFFFF));
			end
			MODE_FILL: begin
				// mostly fresh pairs, now and then a repeat of an older one
				if (fill_idx > 0 && $urandom_range(0, 7) == 0) begin
					i = $urandom_range(0, fill_idx - 1);
				end else begin
					i = fill_idx;
					fill_idx++;
				end
				s = base_s + i;
				f = FIELD_W'(base_f + i);
			end
			MODE_MIXED: begin
				if ($urandom_range(0, 5) == 0) begin
					s = base_s + $urandom_range(0, pool - 1);
					f = FIELD_W'(base_f + $urandom_range(0, pool - 1));
				end else begin
					i = $urandom_range(0, pool - 1);
					s = base_s + i;
					f = FIELD_W'(base_f + i);
				end
			end
			default: begin
				i = $urandom_range(0, pool - 1);
				s = base_s + i;
				f = FIELD_W'(base_f + i);
			end
		endcase
	endfunction

	// sessions of matches for one solved field, each opened by a clear;
	// a few stray clears fall inside sessions too
	task automatic test_random_sessions(int goal);
		session_mode_t mode;
		logic [STAR_W-1:0] base_s;
		logic [FIELD_W-1:0] base_f;
		int pool;
		int len;
		int fill_idx;
		int pick;
		item_t m;
		while (sent_items < goal) begin
			pick = $urandom_range(0, 9);
			if (pick < 4)
				mode = MODE_CONSISTENT;
			else if (pick < 6)
				mode = MODE_SMALL;
			else if (pick == 6)
				mode = MODE_WIDE;
			else if (pick == 7)
				mode = MODE_FILL;
			else
				mode = MODE_MIXED;
			base_s = $urandom;
			base_f = FIELD_W'($urandom_range(0, 16'hFFFF));
			pool = $urandom_range(4, 80);
			fill_idx = 0;
			len = (mode == MODE_FILL) ? $urandom_range(16, 22) : $urandom_range(1, 24);
			idle_off = ($urandom_range(0, 3) == 0);
			for (int n = 0; n < len; n++) begin
				m.start_set = (n == 0) || ($urandom_range(0, 49) == 0);
				for (int k = 0; k < PAIRS_PER_ITEM; k++)
					pick_pair(mode, base_s, base_f, pool, fill_idx, m.star[k], m.field[k]);
				send_match(m);
				sent_items++;
			end
		end
		idle_off = 1'b0;
	endtask

	initial begin
		// reset once, released at a falling edge
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_extremes();
		test_duplicates_in_match();
		test_duplicate_after_conflict();
		test_full_table();
		test_start_clear();
		test_random_sessions(RANDOM_ITEMS);

		@(negedge clk);
		start <= 1'b0;

		// drain, then watch a little longer for stray results
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("pair_dedup_consistency_table test passed");
		else
			$display("pair_dedup_consistency_table test failed");
		$finish;
	end

endmodule
